### hw/rtl/lcbm_pkg.sv
// Shared types and constants for the latched CHR bank mapper.
package lcbm_pkg;

  // Bus access kinds carried in an input item
  typedef enum logic [1:0] {
    OP_CPU_RD = 2'd0,
    OP_CPU_WR = 2'd1,
    OP_PPU_RD = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_e;

  // Memory reached by an access
  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_PRG_ROM = 2'd1,
    TGT_PRG_RAM = 2'd2,
    TGT_CHR_ROM = 2'd3
  } target_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_VARIANT   = 3'd0;
  localparam logic [2:0] CFG_PRG_SIZE  = 3'd1;
  localparam logic [2:0] CFG_PRG_MASK  = 3'd2;
  localparam logic [2:0] CFG_CHR_MASK  = 3'd3;
  localparam logic [2:0] CFG_HAS_RAM   = 3'd4;

  localparam int unsigned CFG_DATA_W = 19;

  // Fixed bank offsets back from the ROM end
  localparam logic [17:0] FIXED_BACK_A000 = 18'h06000;
  localparam logic [17:0] FIXED_BACK_C000 = 18'h04000;
  localparam logic [17:0] FIXED_BACK_E000 = 18'h02000;
  localparam logic [17:0] FIXED_BANK_MASK = 18'h3E000;

  // Register write windows (address bits 15:12)
  localparam logic [3:0] REG_PRG_BANK = 4'hA;
  localparam logic [3:0] REG_CHR_BASE = 4'hB;
  localparam logic [3:0] REG_MIRROR   = 4'hF;

  // Latch trigger tiles: address bits 11:0 exact, bits 11:3 ranged
  localparam logic [11:0] LATCH_FD_ADDR = 12'hFD8;
  localparam logic [11:0] LATCH_FE_ADDR = 12'hFE8;
  localparam logic [8:0]  LATCH_FD_ROW  = 9'h1FB;
  localparam logic [8:0]  LATCH_FE_ROW  = 9'h1FD;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [17:0] phys_offset;
    logic        mirror_horizontal;
  } result_t;

  typedef struct packed {
    logic        variant_wide_prg;
    logic [18:0] prg_rom_size;
    logic [17:0] prg_rom_mask;
    logic [16:0] chr_rom_mask;
    logic        has_prg_ram;
  } cfg_t;

  typedef struct packed {
    logic [3:0]      prg_bank_sel;
    logic [3:0][4:0] chr_bank;
    logic            latch_low;
    logic            latch_high;
    logic            mirror_mode;
  } bank_state_t;

  typedef struct packed {
    logic       prg_we;
    logic [3:0] prg_val;
    logic       chr_we;
    logic [1:0] chr_idx;
    logic [4:0] chr_val;
    logic       mirror_we;
    logic       mirror_val;
    logic       latch_low_we;
    logic       latch_low_val;
    logic       latch_high_we;
    logic       latch_high_val;
  } bank_upd_t;

endpackage

### hw/rtl/lcbm_cfg_regs.sv
// Configuration registers of the mapper, written through a plain write port.
module lcbm_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [lcbm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output lcbm_pkg::cfg_t                    cfg_o
);

  lcbm_pkg::cfg_t cfg_q;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{variant_wide_prg: 1'b0,
                 prg_rom_size:     19'd131072,
                 prg_rom_mask:     18'd131071,
                 chr_rom_mask:     17'd131071,
                 has_prg_ram:      1'b0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcbm_pkg::CFG_VARIANT:  cfg_q.variant_wide_prg <= cfg_wdata_i[0];
        lcbm_pkg::CFG_PRG_SIZE: cfg_q.prg_rom_size     <= cfg_wdata_i[18:0];
        lcbm_pkg::CFG_PRG_MASK: cfg_q.prg_rom_mask     <= cfg_wdata_i[17:0];
        lcbm_pkg::CFG_CHR_MASK: cfg_q.chr_rom_mask     <= cfg_wdata_i[16:0];
        lcbm_pkg::CFG_HAS_RAM:  cfg_q.has_prg_ram      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/lcbm_bank_regs.sv
// Bank select, CHR bank, latch and mirroring registers of the mapper.
module lcbm_bank_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  lcbm_pkg::bank_upd_t     upd_i,
  output lcbm_pkg::bank_state_t   state_o
);

  lcbm_pkg::bank_state_t state_q;

  // State moves only when an item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (en_i) begin
      if (upd_i.prg_we) begin
        state_q.prg_bank_sel <= upd_i.prg_val;
      end
      if (upd_i.chr_we) begin
        state_q.chr_bank[upd_i.chr_idx] <= upd_i.chr_val;
      end
      if (upd_i.mirror_we) begin
        state_q.mirror_mode <= upd_i.mirror_val;
      end
      if (upd_i.latch_low_we) begin
        state_q.latch_low <= upd_i.latch_low_val;
      end
      if (upd_i.latch_high_we) begin
        state_q.latch_high <= upd_i.latch_high_val;
      end
    end
  end

  assign state_o = state_q;

endmodule

### hw/rtl/lcbm_map.sv
// Address decode and offset arithmetic for one bus access, plus state updates.
module lcbm_map #(
  parameter int unsigned PRG_OFFSET_BITS = 18,
  parameter int unsigned CHR_OFFSET_BITS = 17
) (
  input  lcbm_pkg::item_t         item_i,
  input  lcbm_pkg::cfg_t          cfg_i,
  input  lcbm_pkg::bank_state_t   state_i,
  output lcbm_pkg::result_t       result_o,
  output lcbm_pkg::bank_upd_t     upd_o
);

  localparam logic [18:0] PrgCutMask = 19'((20'd1 << PRG_OFFSET_BITS) - 20'd1);
  localparam logic [17:0] ChrCutMask = 18'((19'd1 << CHR_OFFSET_BITS) - 19'd1);

  logic [15:0] addr;
  logic        in_ram_win;
  logic        wide;
  logic [17:0] win_base;
  logic [17:0] fixed_back;
  logic [17:0] fixed_base;
  logic [18:0] prg_sum;
  logic        use_window;
  logic [1:0]  chr_sel;
  logic [16:0] chr_base;
  logic [17:0] chr_sum;
  logic        high_half;
  logic [3:0]  reg_win;

  assign addr       = item_i.address;
  assign wide       = cfg_i.variant_wide_prg;
  assign in_ram_win = (addr[15:13] == 3'b011);
  assign reg_win    = addr[15:12];
  assign high_half  = addr[12];

  // PRG: switchable window or one of the fixed banks near the ROM end
  assign use_window = wide ? (addr[15:14] == 2'b10) : (addr[15:13] == 3'b100);
  assign win_base   = wide ? ({state_i.prg_bank_sel, 14'h0} & cfg_i.prg_rom_mask)
                           : ({1'b0, state_i.prg_bank_sel, 13'h0} & cfg_i.prg_rom_mask);

  always_comb begin
    case (addr[14:13])
      2'b01:   fixed_back = lcbm_pkg::FIXED_BACK_A000;
      2'b10:   fixed_back = lcbm_pkg::FIXED_BACK_C000;
      default: fixed_back = lcbm_pkg::FIXED_BACK_E000;
    endcase
  end

  assign fixed_base = (cfg_i.prg_rom_size[17:0] - fixed_back) & lcbm_pkg::FIXED_BANK_MASK;

  always_comb begin
    if (use_window) begin
      prg_sum = {1'b0, win_base} + (wide ? {5'd0, addr[13:0]} : {6'd0, addr[12:0]});
    end else begin
      prg_sum = {1'b0, fixed_base} + {6'd0, addr[12:0]};
    end
    prg_sum = prg_sum & PrgCutMask;
  end

  // CHR: latch picks the FD or FE bank of the addressed half
  assign chr_sel  = high_half ? {1'b1, state_i.latch_high} : {1'b0, state_i.latch_low};
  assign chr_base = {state_i.chr_bank[chr_sel], 12'h0} & cfg_i.chr_rom_mask;
  assign chr_sum  = ({1'b0, chr_base} + {6'd0, addr[11:0]}) & ChrCutMask;

  // Result and state update per access kind
  always_comb begin
    result_o                   = '0;
    upd_o                      = '0;
    upd_o.prg_val              = item_i.write_data[3:0];
    upd_o.chr_idx              = 2'(reg_win - lcbm_pkg::REG_CHR_BASE);
    upd_o.chr_val              = item_i.write_data[4:0];
    upd_o.mirror_val           = item_i.write_data[0];
    case (item_i.opcode)
      lcbm_pkg::OP_CPU_RD: begin
        if (in_ram_win) begin
          if (cfg_i.has_prg_ram) begin
            result_o.target      = lcbm_pkg::TGT_PRG_RAM;
            result_o.phys_offset = {5'd0, addr[12:0]};
          end
        end else if (addr[15]) begin
          result_o.target      = lcbm_pkg::TGT_PRG_ROM;
          result_o.phys_offset = prg_sum[17:0];
        end
      end
      lcbm_pkg::OP_CPU_WR: begin
        if (in_ram_win) begin
          if (cfg_i.has_prg_ram) begin
            result_o.target      = lcbm_pkg::TGT_PRG_RAM;
            result_o.phys_offset = {5'd0, addr[12:0]};
          end
        end else if (addr[15] && (addr[14] || addr[13])) begin
          if (reg_win == lcbm_pkg::REG_PRG_BANK) begin
            upd_o.prg_we = 1'b1;
          end else if (reg_win == lcbm_pkg::REG_MIRROR) begin
            upd_o.mirror_we = 1'b1;
          end else begin
            upd_o.chr_we = 1'b1;
          end
        end
      end
      lcbm_pkg::OP_PPU_RD: begin
        if (addr[15:13] == 3'b000) begin
          result_o.target      = lcbm_pkg::TGT_CHR_ROM;
          result_o.phys_offset = chr_sum;
          if (high_half) begin
            // High half always uses the ranged tiles
            if (addr[11:3] == lcbm_pkg::LATCH_FD_ROW) begin
              upd_o.latch_high_we  = 1'b1;
              upd_o.latch_high_val = 1'b0;
            end else if (addr[11:3] == lcbm_pkg::LATCH_FE_ROW) begin
              upd_o.latch_high_we  = 1'b1;
              upd_o.latch_high_val = 1'b1;
            end
          end else if (wide) begin
            if (addr[11:3] == lcbm_pkg::LATCH_FD_ROW) begin
              upd_o.latch_low_we  = 1'b1;
              upd_o.latch_low_val = 1'b0;
            end else if (addr[11:3] == lcbm_pkg::LATCH_FE_ROW) begin
              upd_o.latch_low_we  = 1'b1;
              upd_o.latch_low_val = 1'b1;
            end
          end else begin
            // Narrow variant: exact tile address only
            if (addr[11:0] == lcbm_pkg::LATCH_FD_ADDR) begin
              upd_o.latch_low_we  = 1'b1;
              upd_o.latch_low_val = 1'b0;
            end else if (addr[11:0] == lcbm_pkg::LATCH_FE_ADDR) begin
              upd_o.latch_low_we  = 1'b1;
              upd_o.latch_low_val = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    // Mirroring reported as it stands after this access
    result_o.mirror_horizontal = upd_o.mirror_we ? upd_o.mirror_val
                                                 : state_i.mirror_mode;
  end

endmodule

### hw/rtl/latched_chr_bank_mapper_core.sv
// Flow: an accepted item waits in the input register and moves into the result
// register once that is free or being drained; the result is taken from there.
// Throughput: one item per cycle while the output does not stall; the mapping is
// one pass of decode and an 18-bit add between the input and result registers.
// Reset (asynchronous, active low) empties both registers, zeroes the bank and
// latch registers and loads the configuration defaults.
module latched_chr_bank_mapper_core #(
  parameter int unsigned PRG_OFFSET_BITS = 18,
  parameter int unsigned CHR_OFFSET_BITS = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // opcode, address, write_data
  // Result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // target, phys_offset, mirror_horizontal
  // Configuration
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [lcbm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  lcbm_pkg::cfg_t        cfg;
  lcbm_pkg::bank_state_t bank_state;
  lcbm_pkg::bank_upd_t   bank_upd;
  lcbm_pkg::item_t       item_q;
  lcbm_pkg::result_t     result_d;
  lcbm_pkg::result_t     result_q;
  logic                  in_valid_q;
  logic                  out_valid_q;
  logic                  adv;
  logic                  in_take;

  // Item moves to the result register when that is free or being drained
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= {s_axis_tdata[1:0], s_axis_tdata[17:2], s_axis_tdata[25:18]};
    end
  end

  lcbm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lcbm_map #(
    .PRG_OFFSET_BITS (PRG_OFFSET_BITS),
    .CHR_OFFSET_BITS (CHR_OFFSET_BITS)
  ) u_map (
    .item_i   (item_q),
    .cfg_i    (cfg),
    .state_i  (bank_state),
    .result_o (result_d),
    .upd_o    (bank_upd)
  );

  lcbm_bank_regs u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .upd_i   (bank_upd),
    .state_o (bank_state)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, result_q.mirror_horizontal, result_q.phys_offset,
                          result_q.target};

  // No new item may land while a stalled item still sits in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input register overrun while result stalled");

  // Bank and latch state only changes when an item is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(bank_state))
    else $error("bank state changed without an item");

  // Register writes reach no memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && item_q.opcode == lcbm_pkg::OP_CPU_WR && item_q.address[15]
      && (item_q.address[14] || item_q.address[13])
    |=> result_q.target == lcbm_pkg::TGT_NONE)
    else $error("register write mapped to a memory");

  // An unmapped result carries a zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.target == lcbm_pkg::TGT_NONE |-> result_q.phys_offset == '0)
    else $error("unmapped result with non-zero offset");

endmodule

### bench/tb.sv
// Self-checking bench for the latched CHR bank mapper core: directed table, then random accesses.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned PRG_BITS = 18;
  localparam int unsigned CHR_BITS = 17;
  localparam int RANDOM_PHASES   = 8;
  localparam int ACCESSES_PHASE  = 190;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_AT_ITEM    = 700;
  localparam int HOLD_CYCLES     = 160;
  localparam logic [31:0] PRG_CUT = (32'd1 << PRG_BITS) - 32'd1;
  localparam logic [31:0] CHR_CUT = (32'd1 << CHR_BITS) - 32'd1;

  // One row of the directed table; typed rows carry their expected result
  typedef struct packed {
    lcbm_pkg::opcode_e op;
    logic [15:0]       address;
    logic [7:0]        write_data;
    logic              typed;
    lcbm_pkg::target_e target;
    logic [17:0]       phys_offset;
    logic              mirror;
  } probe_t;

  // Directed accesses, all at reset configuration
  localparam probe_t PROBES [25] = '{
    '{lcbm_pkg::OP_CPU_RD, 16'h0000, 8'h00, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_RD, 16'h4000, 8'hFF, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_RD, 16'h6000, 8'h00, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_WR, 16'h7FFF, 8'hFF, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_RD, 16'h8000, 8'h00, 1'b1, lcbm_pkg::TGT_PRG_ROM, 18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_RD, 16'hA000, 8'h00, 1'b1, lcbm_pkg::TGT_PRG_ROM, 18'h1A000, 1'b0},
    '{lcbm_pkg::OP_CPU_RD, 16'hC000, 8'h00, 1'b1, lcbm_pkg::TGT_PRG_ROM, 18'h1C000, 1'b0},
    '{lcbm_pkg::OP_CPU_RD, 16'hFFFF, 8'hFF, 1'b1, lcbm_pkg::TGT_PRG_ROM, 18'h1FFFF, 1'b0},
    '{lcbm_pkg::OP_CPU_WR, 16'h9FFF, 8'hFF, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_PPU_RD, 16'h0000, 8'h00, 1'b1, lcbm_pkg::TGT_CHR_ROM, 18'h00000, 1'b0},
    '{lcbm_pkg::OP_PPU_RD, 16'h2000, 8'h00, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_UNUSED, 16'hFFFF, 8'hFF, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_WR, 16'hA000, 8'hFF, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_RD, 16'h9FFF, 8'h00, 1'b0, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_WR, 16'hB000, 8'h1F, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_WR, 16'hC000, 8'h15, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_WR, 16'hD000, 8'h0A, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_WR, 16'hEFFF, 8'hFF, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_PPU_RD, 16'h0FD8, 8'h00, 1'b0, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_PPU_RD, 16'h0FE8, 8'h00, 1'b0, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_PPU_RD, 16'h0FD9, 8'h00, 1'b0, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_PPU_RD, 16'h1FE8, 8'h00, 1'b0, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_PPU_RD, 16'h1FDF, 8'h00, 1'b0, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0},
    '{lcbm_pkg::OP_CPU_WR, 16'hF000, 8'hFF, 1'b1, lcbm_pkg::TGT_NONE,    18'h00000, 1'b1},
    '{lcbm_pkg::OP_CPU_RD, 16'hFFFF, 8'h00, 1'b0, lcbm_pkg::TGT_NONE,    18'h00000, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // opcode [1:0], address [17:2], write_data [25:18]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // target [1:0], phys_offset [19:2], mirror_horizontal [20]
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [lcbm_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Predictor state: own copy of configuration and bank registers
  lcbm_pkg::cfg_t        mapper_cfg;
  lcbm_pkg::bank_state_t banks;
  lcbm_pkg::result_t     expected_maps [$];

  int   items_sent = 0;
  int   results_seen = 0;
  int   latch_flips = 0;
  int   errors = 0;
  int   cycles = 0;
  logic hold_rx = 1'b0;
  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;

  latched_chr_bank_mapper_core #(
    .PRG_OFFSET_BITS(PRG_BITS),
    .CHR_OFFSET_BITS(CHR_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Base of a fixed 8 KB window, counted back from the ROM end
  function automatic logic [31:0] fixed_bank(input logic [17:0] back);
    return ({13'b0, mapper_cfg.prg_rom_size} - {14'b0, back})
           & {14'b0, lcbm_pkg::FIXED_BANK_MASK};
  endfunction

  // Work out the mapping of one access and apply its side effects
  function automatic lcbm_pkg::result_t map_access(input lcbm_pkg::item_t it);
    logic [31:0]       a;
    logic [31:0]       off;
    logic [1:0]        sel;
    logic              high;
    logic              ranged;
    logic              old_latch;
    logic              hit_fd;
    logic              hit_fe;
    logic [3:0]        win;
    lcbm_pkg::result_t res;
    a = {16'b0, it.address};
    off = '0;
    res.target = lcbm_pkg::TGT_NONE;
    case (lcbm_pkg::opcode_e'(it.opcode))
      lcbm_pkg::OP_CPU_RD: begin
        if (it.address[15:13] == 3'b011) begin
          if (mapper_cfg.has_prg_ram) begin
            res.target = lcbm_pkg::TGT_PRG_RAM;
            off = a & 32'h1FFF;
          end
        end else if (it.address[15]) begin
          res.target = lcbm_pkg::TGT_PRG_ROM;
          if (mapper_cfg.variant_wide_prg && it.address < 16'hC000)
            off = (({28'b0, banks.prg_bank_sel} << 14) & {14'b0, mapper_cfg.prg_rom_mask})
                  + (a & 32'h3FFF);
          else if (!mapper_cfg.variant_wide_prg && it.address < 16'hA000)
            off = (({28'b0, banks.prg_bank_sel} << 13) & {14'b0, mapper_cfg.prg_rom_mask})
                  + (a & 32'h1FFF);
          else if (it.address < 16'hC000)
            off = fixed_bank(lcbm_pkg::FIXED_BACK_A000) + (a & 32'h1FFF);
          else if (it.address < 16'hE000)
            off = fixed_bank(lcbm_pkg::FIXED_BACK_C000) + (a & 32'h1FFF);
          else
            off = fixed_bank(lcbm_pkg::FIXED_BACK_E000) + (a & 32'h1FFF);
          off = off & PRG_CUT;
        end
      end
      lcbm_pkg::OP_CPU_WR: begin
        if (it.address[15:13] == 3'b011) begin
          if (mapper_cfg.has_prg_ram) begin
            res.target = lcbm_pkg::TGT_PRG_RAM;
            off = a & 32'h1FFF;
          end
        end else if (it.address >= 16'hA000) begin
          win = it.address[15:12];
          if (win == lcbm_pkg::REG_PRG_BANK)
            banks.prg_bank_sel = it.write_data[3:0];
          else if (win == lcbm_pkg::REG_MIRROR)
            banks.mirror_mode = it.write_data[0];
          else
            banks.chr_bank[2'(win - lcbm_pkg::REG_CHR_BASE)] = it.write_data[4:0];
        end
      end
      lcbm_pkg::OP_PPU_RD: begin
        if (it.address[15:13] == 3'b000) begin
          // read uses the bank selected before this access
          high = it.address[12];
          sel = high ? {1'b1, banks.latch_high} : {1'b0, banks.latch_low};
          res.target = lcbm_pkg::TGT_CHR_ROM;
          off = (({27'b0, banks.chr_bank[sel]} << 12) & {15'b0, mapper_cfg.chr_rom_mask})
                + (a & 32'hFFF);
          off = off & CHR_CUT;
          // high half always uses tile ranges; low half only in the wide variant
          ranged = high || mapper_cfg.variant_wide_prg;
          old_latch = high ? banks.latch_high : banks.latch_low;
          hit_fd = ranged ? it.address[11:3] == lcbm_pkg::LATCH_FD_ROW
                          : it.address[11:0] == lcbm_pkg::LATCH_FD_ADDR;
          hit_fe = ranged ? it.address[11:3] == lcbm_pkg::LATCH_FE_ROW
                          : it.address[11:0] == lcbm_pkg::LATCH_FE_ADDR;
          if (hit_fd) begin
            if (high) banks.latch_high = 1'b0;
            else banks.latch_low = 1'b0;
          end else if (hit_fe) begin
            if (high) banks.latch_high = 1'b1;
            else banks.latch_low = 1'b1;
          end
          if (old_latch != (high ? banks.latch_high : banks.latch_low))
            latch_flips++;
        end
      end
      default: ;
    endcase
    res.phys_offset = off[17:0];
    res.mirror_horizontal = banks.mirror_mode;
    return res;
  endfunction

  // Random access, biased towards latch tiles and register windows
  function automatic lcbm_pkg::item_t rand_access();
    lcbm_pkg::item_t it;
    int              pick;
    int              r;
    logic [11:0]     tile;
    it.write_data = 8'($urandom);
    it.address = 16'($urandom);
    pick = $urandom_range(0, 99);
    r = $urandom_range(0, 9);
    if (pick < 40) begin
      it.opcode = lcbm_pkg::OP_PPU_RD;
      if (r < 5) begin
        tile = $urandom_range(0, 1) ? lcbm_pkg::LATCH_FD_ADDR : lcbm_pkg::LATCH_FE_ADDR;
        if ($urandom_range(0, 1)) tile[2:0] = 3'($urandom);
        it.address = {3'b000, 1'($urandom), tile};
      end else if (r < 9) begin
        it.address[15:13] = 3'b000;
      end
    end else if (pick < 65) begin
      it.opcode = lcbm_pkg::OP_CPU_WR;
      if (r < 6) it.address[15:12] = 4'($urandom_range(10, 15));
      else if (r < 8) it.address[15:13] = 3'b011;
    end else if (pick < 95) begin
      it.opcode = lcbm_pkg::OP_CPU_RD;
      if (r < 6) it.address[15] = 1'b1;
      else if (r < 8) it.address[15:13] = 3'b011;
    end else begin
      it.opcode = lcbm_pkg::OP_UNUSED;
    end
    return it;
  endfunction

  // Offer one item, predict its result on acceptance
  task automatic send_access(input lcbm_pkg::item_t it, input logic typed,
                             input lcbm_pkg::result_t typed_res);
    int                gap;
    lcbm_pkg::result_t res;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, it.write_data, it.address, it.opcode};
    do @(posedge clk_i); while (!s_axis_tready);
    res = map_access(it);
    expected_maps.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // Configuration write, mirrored into the predictor with the same width cut
  task automatic write_reg(input logic [2:0] idx,
                           input logic [lcbm_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      lcbm_pkg::CFG_VARIANT:  mapper_cfg.variant_wide_prg = val[0];
      lcbm_pkg::CFG_PRG_SIZE: mapper_cfg.prg_rom_size = val;
      lcbm_pkg::CFG_PRG_MASK: mapper_cfg.prg_rom_mask = val[17:0];
      lcbm_pkg::CFG_CHR_MASK: mapper_cfg.chr_rom_mask = val[16:0];
      lcbm_pkg::CFG_HAS_RAM:  mapper_cfg.has_prg_ram = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Drain all outstanding results, then allow the pipeline to settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Pick a configuration for a random phase; the first four are the extremes
  task automatic setup_phase(input int ph);
    logic        variant;
    logic        ram;
    logic [18:0] size;
    logic [17:0] pmask;
    logic [16:0] cmask;
    case (ph)
      1: begin
        variant = 1'b1; size = 19'h08000; pmask = 18'h3FFFF; cmask = 17'h1FFFF; ram = 1'b1;
      end
      2: begin
        variant = 1'b0; size = 19'h40000; pmask = 18'h00000; cmask = 17'h00000; ram = 1'b1;
      end
      3: begin
        variant = 1'b1; size = 19'h40000; pmask = 18'h07FFF; cmask = 17'h03FFF; ram = 1'b0;
      end
      4: begin
        variant = 1'b0; size = 19'h08000; pmask = 18'h3FFFF; cmask = 17'h1FFFF; ram = 1'b0;
      end
      default: begin
        variant = 1'($urandom);
        ram = 1'($urandom);
        size = 19'($urandom_range(32768, 262144));
        pmask = $urandom_range(0, 1) ? 18'($urandom)
                                     : 18'((32'd1 << $urandom_range(13, 18)) - 32'd1);
        cmask = $urandom_range(0, 1) ? 17'($urandom)
                                     : 17'((32'd1 << $urandom_range(12, 17)) - 32'd1);
      end
    endcase
    // junk in the upper bits must be cut off by the register width
    write_reg(lcbm_pkg::CFG_VARIANT, {18'($urandom), variant});
    write_reg(lcbm_pkg::CFG_PRG_SIZE, size);
    write_reg(lcbm_pkg::CFG_PRG_MASK, {1'($urandom), pmask});
    write_reg(lcbm_pkg::CFG_CHR_MASK, {2'($urandom), cmask});
    write_reg(lcbm_pkg::CFG_HAS_RAM, {18'($urandom), ram});
    // unused index, must be ignored
    write_reg(3'($urandom_range(5, 7)), 19'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random stalls, checks against the oldest expectation
  initial begin
    int                stall;
    lcbm_pkg::result_t want;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      while (hold_rx) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_seen++;
      if (expected_maps.size() == 0) begin
        $error("unexpected result item: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_maps.pop_front();
        if (want.target !== m_axis_tdata[1:0]) begin
          $error("target: expected %0d, got %0d", want.target, m_axis_tdata[1:0]);
          errors++;
        end
        if (want.phys_offset !== m_axis_tdata[19:2]) begin
          $error("phys_offset: expected %h, got %h", want.phys_offset, m_axis_tdata[19:2]);
          errors++;
        end
        if (want.mirror_horizontal !== m_axis_tdata[20]) begin
          $error("mirror_horizontal: expected %0d, got %0d", want.mirror_horizontal,
                 m_axis_tdata[20]);
          errors++;
        end
      end
    end
  end

  // Long receiver hold-off so the core fills up and stalls its input
  initial begin
    wait (items_sent >= HOLD_AT_ITEM);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Main sequence
  initial begin
    lcbm_pkg::result_t typed_res;
    lcbm_pkg::item_t   it;
    mapper_cfg = '{variant_wide_prg: 1'b0, prg_rom_size: 19'd131072,
                   prg_rom_mask: 18'h1FFFF, chr_rom_mask: 17'h1FFFF, has_prg_ram: 1'b0};
    banks = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table
    foreach (PROBES[i]) begin
      it.opcode = PROBES[i].op;
      it.address = PROBES[i].address;
      it.write_data = PROBES[i].write_data;
      typed_res.target = PROBES[i].target;
      typed_res.phys_offset = PROBES[i].phys_offset;
      typed_res.mirror_horizontal = PROBES[i].mirror;
      send_access(it, PROBES[i].typed, typed_res);
    end

    // random phases, each under its own configuration
    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      drain();
      setup_phase(ph);
      for (int n = 0; n < ACCESSES_PHASE; n++)
        send_access(rand_access(), 1'b0, '0);
    end
    drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d accesses under %0d mapper settings, incl. both variants and RAM on/off.",
             items_sent, RANDOM_PHASES + 1);
    $display("Checked %0d results; %0d CHR latch flips seen.", results_seen, latch_flips);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/lcbm_pkg.sv
hw/rtl/lcbm_cfg_regs.sv
hw/rtl/lcbm_bank_regs.sv
hw/rtl/lcbm_map.sv
hw/rtl/latched_chr_bank_mapper_core.sv
bench/tb.sv
